@@ rtl/mlls_pkg.sv @@
// Shared types and constants for the multi-lane loop sequencer.
package mlls_pkg;

   // Default sizes; byte-wide packing of the masks and counts is fixed.
   localparam int LANES_DEF        = 8;
   localparam int SEGMENT_BITS_DEF = 8;
   localparam int LANE_FIELD_BITS  = 8;
   localparam int REPEAT_BITS      = 8;

   // Register indexes of the configuration port
   localparam logic [2:0] REG_LOOP_LOCK      = 3'd0;
   localparam logic [2:0] REG_LOOP_MASK      = 3'd1;
   localparam logic [2:0] REG_AUTOSTART_MASK = 3'd2;
   localparam logic [2:0] REG_SEGMENT_COUNTS = 3'd3;
   localparam logic [2:0] REG_REPEAT_COUNTS  = 3'd4;

   // Lane mode
   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_RUN  = 2'd1,
      MODE_PEND = 2'd2
   } lane_mode_type;

   // Per-lane controls for one step
   typedef struct packed {
      logic tick;
      logic reload_all;
      logic restart;
      logic start;
      logic stop;
      logic seg_end;
      logic loop_release;
      logic loop_lock;
      logic loop_en;
      logic autostart;
   } lane_ctl_type;

   // Per-lane status of one step
   typedef struct packed {
      logic running;
      logic pending;
      logic looped;
      logic advanced;
      logic finished;
      logic run_pre;
   } lane_stat_type;

endpackage

@@ rtl/multi_lane_loop_sequencer.sv @@
// Top level of the multi-lane loop sequencer: channels, registers and lane array.
//
// Usage: each transfer on the req channel is one step of the timeline. req_tuser
// selects a tick (0) or a reload of all lanes from the autostart mask (1); req_tdata
// carries the per-lane restart, start and stop hits and the segment-end flags.
// Every step gives exactly one transfer on the rsp channel with the lane masks
// after that step.
// A step is captured in the input register, then resolved for all lanes and shown in
// the result register once that register is free or being drained; rsp_tvalid then
// marks the result valid until it is taken.
// Throughput: one step per cycle while rsp_tready is high; the only loop is the lane
// state update, which is combinational from the lane registers back to them.
// Reset: all lanes idle with segment and repeat counts at zero, registers cleared.
// Stall: while rsp_tready is low the result holds; one more step can wait in the
// input register, then req_tready drops until the result is taken.
// Registers sit at byte address 8*i on the 64-bit csr port; the user must write them
// only while no step is in flight, as the block itself does not enforce it.
module multi_lane_loop_sequencer #(
   parameter int LANES        = mlls_pkg::LANES_DEF,
   parameter int SEGMENT_BITS = mlls_pkg::SEGMENT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // restart_hits[7:0], start_hits[15:8], stop_hits[23:16], segment_end[31:24]
   input  logic [31:0] req_tdata,
   // req_type[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // running_mask[7:0], pending_mask[15:8], looped_mask[23:16],
   // advanced_mask[31:24], finished_mask[39:32]
   output logic [39:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int FB = mlls_pkg::LANE_FIELD_BITS;

   // Configuration registers
   logic          loop_lock_ff;
   logic [FB-1:0] loop_mask_ff;
   logic [FB-1:0] autostart_ff;
   logic [63:0]   seg_counts_ff;
   logic [63:0]   rep_counts_ff;
   logic          csr_write;
   logic [2:0]    csr_index;

   // Input and result registers
   logic          in_valid_ff;
   logic          in_type_ff;
   logic [31:0]   in_data_ff;
   logic          out_valid_ff;
   logic [39:0]   out_data_ff, out_data_in;
   logic          advance;

   // Lane masks
   logic [FB-1:0] running_w, pending_w, looped_w, advanced_w, finished_w, run_pre_w;
   logic          loop_release;
   logic          tick;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[5:3];

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         loop_lock_ff  <= 1'b0;
         loop_mask_ff  <= '0;
         autostart_ff  <= '0;
         seg_counts_ff <= '0;
         rep_counts_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            mlls_pkg::REG_LOOP_LOCK:      loop_lock_ff  <= csr_pwdata[0];
            mlls_pkg::REG_LOOP_MASK:      loop_mask_ff  <= csr_pwdata[FB-1:0];
            mlls_pkg::REG_AUTOSTART_MASK: autostart_ff  <= csr_pwdata[FB-1:0];
            mlls_pkg::REG_SEGMENT_COUNTS: seg_counts_ff <= csr_pwdata;
            mlls_pkg::REG_REPEAT_COUNTS:  rep_counts_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   // Read back configuration registers
   always_comb begin
      unique case (csr_index)
         mlls_pkg::REG_LOOP_LOCK:      csr_prdata = {63'd0, loop_lock_ff};
         mlls_pkg::REG_LOOP_MASK:      csr_prdata = {{(64-FB){1'b0}}, loop_mask_ff};
         mlls_pkg::REG_AUTOSTART_MASK: csr_prdata = {{(64-FB){1'b0}}, autostart_ff};
         mlls_pkg::REG_SEGMENT_COUNTS: csr_prdata = seg_counts_ff;
         mlls_pkg::REG_REPEAT_COUNTS:  csr_prdata = rep_counts_ff;
         default:                      csr_prdata = '0;
      endcase
   end

   // Advance a step into the result register when it is free or being drained
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign tick       = !in_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_type_ff <= req_tuser;
         in_data_ff <= req_tdata;
      end
   end

   // Lane array; lanes past LANES read as zero
   for (genvar g = 0; g < FB; g++) begin : g_lane
      if (g < LANES) begin : g_used
         mlls_pkg::lane_ctl_type  ctl;
         mlls_pkg::lane_stat_type stat;

         always_comb begin
            ctl.tick         = tick;
            ctl.reload_all   = in_type_ff;
            ctl.restart      = in_data_ff[g];
            ctl.start        = in_data_ff[FB + g];
            ctl.stop         = in_data_ff[2*FB + g];
            ctl.seg_end      = in_data_ff[3*FB + g];
            ctl.loop_release = loop_release;
            ctl.loop_lock    = loop_lock_ff;
            ctl.loop_en      = loop_mask_ff[g];
            ctl.autostart    = autostart_ff[g];
         end

         mlls_lane #(
            .SEGMENT_BITS(SEGMENT_BITS)
         ) u_lane (
            .clock      (clock),
            .reset      (reset),
            .step       (advance),
            .ctl        (ctl),
            .seg_count  (seg_counts_ff[FB*g +: SEGMENT_BITS]),
            .rep_wanted (rep_counts_ff[FB*g +: mlls_pkg::REPEAT_BITS]),
            .stat       (stat)
         );

         assign running_w[g]  = stat.running;
         assign pending_w[g]  = stat.pending;
         assign looped_w[g]   = stat.looped;
         assign advanced_w[g] = stat.advanced;
         assign finished_w[g] = stat.finished;
         assign run_pre_w[g]  = stat.run_pre;
      end else begin : g_unused
         assign running_w[g]  = 1'b0;
         assign pending_w[g]  = 1'b0;
         assign looped_w[g]   = 1'b0;
         assign advanced_w[g] = 1'b0;
         assign finished_w[g] = 1'b0;
         assign run_pre_w[g]  = 1'b0;
      end
   end

   // Release waiting lanes under loop lock on a tick in which some lane finishes and none still runs
   assign loop_release = tick && loop_lock_ff && (|finished_w) && !(|run_pre_w);

   assign out_data_in = {finished_w, advanced_w, looped_w, pending_w, running_w};

   // Hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // A lane is never both running and waiting to loop
   a_run_pend_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[7:0] & rsp_tdata[15:8]) == 8'd0))
      else $error("lane both running and pending");

   // A lane cannot both advance and finish in one step
   a_adv_fin_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[31:24] & rsp_tdata[39:32]) == 8'd0))
      else $error("lane both advanced and finished");

   // A looped lane ends the step running
   a_looped_running: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[23:16] & ~rsp_tdata[7:0]) == 8'd0))
      else $error("looped lane not running");

   // A full input register behind a stalled result blocks new transfers
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && in_valid_ff) |-> !req_tready)
      else $error("transfer accepted with both stages full");

   // A taken result with nothing behind it leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !in_valid_ff) |=> !rsp_tvalid)
      else $error("result repeated after transfer");

endmodule

@@ rtl/mlls_lane.sv @@
// One sequencer lane: mode, active segment and repeat count with their step logic.
module mlls_lane #(
   parameter int SEGMENT_BITS = mlls_pkg::SEGMENT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  mlls_pkg::lane_ctl_type             ctl,
   input  logic [SEGMENT_BITS-1:0]            seg_count,
   input  logic [mlls_pkg::REPEAT_BITS-1:0]   rep_wanted,
   output mlls_pkg::lane_stat_type            stat
);

   localparam logic [mlls_pkg::REPEAT_BITS-1:0] REP_ONE = 1;
   localparam logic [mlls_pkg::REPEAT_BITS-1:0] REP_MAX = '1;

   mlls_pkg::lane_mode_type mode_ff, mode_in;
   logic [SEGMENT_BITS-1:0] seg_ff, seg_in;
   logic [mlls_pkg::REPEAT_BITS-1:0] rep_ff, rep_in;

   logic                             cnt_nz;
   logic                             reload;
   mlls_pkg::lane_mode_type          mode_hit;
   mlls_pkg::lane_mode_type          mode_adv;
   logic [SEGMENT_BITS-1:0]          seg_hit;
   logic [SEGMENT_BITS:0]            seg_next;
   logic [mlls_pkg::REPEAT_BITS-1:0] rep_hit;
   logic                             adv_cond;
   logic                             advanced;
   logic                             finished;
   logic                             eligible;
   logic                             looped;

   // Apply the hits, then advance on segment end
   always_comb begin
      cnt_nz = (seg_count != '0);
      reload = ctl.tick && cnt_nz &&
               (ctl.restart || (mode_ff != mlls_pkg::MODE_RUN && ctl.start));
      mode_hit = reload ? mlls_pkg::MODE_RUN : mode_ff;
      seg_hit  = reload ? '0 : seg_ff;
      rep_hit  = reload ? '0 : rep_ff;
      if (ctl.tick && ctl.stop && mode_hit != mlls_pkg::MODE_IDLE) begin
         mode_hit = mlls_pkg::MODE_IDLE;
      end
      adv_cond = ctl.tick && mode_hit == mlls_pkg::MODE_RUN && cnt_nz && ctl.seg_end;
      seg_next = {1'b0, seg_hit} + {{SEGMENT_BITS{1'b0}}, 1'b1};
      advanced = adv_cond && (seg_next < {1'b0, seg_count});
      finished = adv_cond && !(seg_next < {1'b0, seg_count});
      mode_adv = finished ? mlls_pkg::MODE_PEND : mode_hit;
      eligible = ctl.loop_en || (rep_wanted > REP_ONE && rep_hit < (rep_wanted - REP_ONE));
      looped   = mode_adv == mlls_pkg::MODE_PEND && eligible &&
                 ((finished && !ctl.loop_lock) || ctl.loop_release);
   end

   // Next lane state
   always_comb begin
      mode_in = mode_adv;
      seg_in  = advanced ? seg_next[SEGMENT_BITS-1:0] : seg_hit;
      rep_in  = rep_hit;
      if (looped) begin
         mode_in = mlls_pkg::MODE_RUN;
         seg_in  = '0;
         rep_in  = (rep_hit == REP_MAX) ? rep_hit : rep_hit + REP_ONE;
      end
      if (ctl.reload_all) begin
         mode_in = (ctl.autostart && cnt_nz) ? mlls_pkg::MODE_RUN : mlls_pkg::MODE_IDLE;
         seg_in  = '0;
         rep_in  = '0;
      end
   end

   // Status toward the result
   always_comb begin
      stat.running  = (mode_in == mlls_pkg::MODE_RUN);
      stat.pending  = (mode_in == mlls_pkg::MODE_PEND);
      stat.looped   = looped && !ctl.reload_all;
      stat.advanced = advanced && !ctl.reload_all;
      stat.finished = finished && !ctl.reload_all;
      stat.run_pre  = (mode_adv == mlls_pkg::MODE_RUN);
   end

   // Hold state between steps
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= mlls_pkg::MODE_IDLE;
         seg_ff  <= '0;
         rep_ff  <= '0;
      end else if (step) begin
         mode_ff <= mode_in;
         seg_ff  <= seg_in;
         rep_ff  <= rep_in;
      end
   end

endmodule
